@@ hw/rtl/rgb2hsv_pkg.sv @@
// Types, constants and the division and rounding steps of the RGB to HSV converter.
// Depends on nothing; the converter top level takes everything by scoped name.

package rgb2hsv_pkg;

  localparam int ColorW = 8;
  localparam int HueW   = 9;
  localparam int PctW   = 7;
  localparam int NumW   = 15;
  localparam int QuoW   = 7;

  localparam logic [NumW-1:0] HueScale = NumW'(60);
  localparam logic [NumW-1:0] PctScale = NumW'(100);
  localparam logic [ColorW-1:0] ValDen = ColorW'(255);
  localparam logic [HueW-1:0] GreenBase = HueW'(120);
  localparam logic [HueW-1:0] BlueBase  = HueW'(240);
  localparam logic [HueW-1:0] FullTurn  = HueW'(360);

  typedef enum logic [1:0] {
    SEC_GRAY,
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  typedef struct packed {
    logic [ColorW-1:0] hi;
    logic [ColorW-1:0] lo;
    sector_t           sector;
    logic              neg;
    logic [ColorW-1:0] mag;
  } front_t;

  typedef struct packed {
    logic [NumW-1:0]   rem;
    logic [ColorW-1:0] den;
    logic [QuoW-1:0]   quo;
  } div_lane_t;

  typedef struct packed {
    sector_t   sector;
    logic      neg;
    logic      black;
    div_lane_t hue;
    div_lane_t sat;
    div_lane_t val;
  } div_word_t;

  typedef struct packed {
    sector_t         sector;
    logic            neg;
    logic            black;
    logic [QuoW-1:0] hue;
    logic [PctW-1:0] sat;
    logic [PctW-1:0] val;
  } round_word_t;

  // One restoring step: decide quotient bit k.
  function automatic div_lane_t div_step(input div_lane_t l, input logic [2:0] k);
    logic [NumW-1:0] sub;
    div_lane_t       res;
    sub = NumW'(l.den) << k;
    res = l;
    if (l.rem >= sub) begin
      res.rem    = l.rem - sub;
      res.quo[k] = 1'b1;
    end
    return res;
  endfunction

  // Round quotient to nearest, ties to even.
  function automatic logic [QuoW-1:0] round_even(input div_lane_t l);
    logic [ColorW:0] twice;
    logic            up;
    twice = {l.rem[ColorW-1:0], 1'b0};
    up    = (twice > {1'b0, l.den}) || ((twice == {1'b0, l.den}) && l.quo[0]);
    return l.quo + QuoW'(up);
  endfunction

endpackage

@@ hw/rtl/rgb_to_hsv_converter.sv @@
// RGB to HSV converter: pipelined max/min, products, restoring divider and rounding.
// Depends on rgb2hsv_pkg.
//
// Usage:
//   Input words arrive on s_axis (red, green, blue, 8 bits each). One result word
//   leaves on m_axis per input word, in order: hue in degrees (0..359),
//   saturation and value in percent (0..100).
//   The pipeline has one stage for max, min and sector, one for the products,
//   seven for the divider (one quotient bit per stage, three lanes side by side)
//   and two for rounding and hue assembly.
//   Throughput is one word per cycle while m_axis is not stalled; the divider stages set the depth.
//   Reset clears every valid bit; payload registers keep whatever they hold.
//   When the receiver drops m_axis_tready while a result waits, the whole pipeline
//   holds and s_axis_tready falls in the same cycle; nothing is lost or repeated.

module rgb_to_hsv_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red_in[7:0], green_in[15:8], blue_in[23:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // hue_deg[8:0], sat_pct[15:9], val_pct[22:16], zero
);

  localparam int DivStages = rgb2hsv_pkg::QuoW;

  logic en;

  logic [rgb2hsv_pkg::ColorW-1:0] red_in, green_in, blue_in;

  logic                 a_vld;
  rgb2hsv_pkg::front_t  a, a_next;
  logic                 b_vld;
  rgb2hsv_pkg::div_word_t b, b_next;
  logic [DivStages-1:0] dv_vld;
  rgb2hsv_pkg::div_word_t dv [DivStages];
  logic                 r_vld;
  rgb2hsv_pkg::round_word_t r, r_next;
  logic                 out_vld;
  logic [rgb2hsv_pkg::HueW-1:0] hue_deg, hue_next;
  logic [rgb2hsv_pkg::PctW-1:0] sat_pct, val_pct;

  assign en            = !out_vld || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata  = {1'b0, val_pct, sat_pct, hue_deg};

  assign red_in   = s_axis_tdata[7:0];
  assign green_in = s_axis_tdata[15:8];
  assign blue_in  = s_axis_tdata[23:16];

  // Stage A: max, min, sector and signed difference.
  always_comb begin
    logic red_top, green_top, gray;
    red_top   = (red_in >= green_in) && (red_in >= blue_in);
    green_top = (green_in >= blue_in);
    gray      = (red_in == green_in) && (green_in == blue_in);
    a_next    = '0;
    if (red_top) begin
      a_next.hi = red_in;
    end else if (green_top) begin
      a_next.hi = green_in;
    end else begin
      a_next.hi = blue_in;
    end
    if ((red_in <= green_in) && (red_in <= blue_in)) begin
      a_next.lo = red_in;
    end else if (green_in <= blue_in) begin
      a_next.lo = green_in;
    end else begin
      a_next.lo = blue_in;
    end
    priority if (gray) begin
      a_next.sector = rgb2hsv_pkg::SEC_GRAY;
      a_next.neg    = 1'b0;
      a_next.mag    = '0;
    end else if (red_top) begin
      a_next.sector = rgb2hsv_pkg::SEC_RED;
      a_next.neg    = green_in < blue_in;
      a_next.mag    = (green_in < blue_in) ? blue_in - green_in : green_in - blue_in;
    end else if (green_top) begin
      a_next.sector = rgb2hsv_pkg::SEC_GREEN;
      a_next.neg    = blue_in < red_in;
      a_next.mag    = (blue_in < red_in) ? red_in - blue_in : blue_in - red_in;
    end else begin
      a_next.sector = rgb2hsv_pkg::SEC_BLUE;
      a_next.neg    = red_in < green_in;
      a_next.mag    = (red_in < green_in) ? green_in - red_in : red_in - green_in;
    end
  end

  // Stage B: span and the three numerators.
  always_comb begin
    logic [rgb2hsv_pkg::ColorW-1:0] span;
    span          = a.hi - a.lo;
    b_next.sector = a.sector;
    b_next.neg    = a.neg;
    b_next.black  = (a.hi == '0);
    b_next.hue.rem = rgb2hsv_pkg::NumW'(a.mag) * rgb2hsv_pkg::HueScale;
    b_next.hue.den = span;
    b_next.hue.quo = '0;
    b_next.sat.rem = rgb2hsv_pkg::NumW'(span) * rgb2hsv_pkg::PctScale;
    b_next.sat.den = a.hi;
    b_next.sat.quo = '0;
    b_next.val.rem = rgb2hsv_pkg::NumW'(a.hi) * rgb2hsv_pkg::PctScale;
    b_next.val.den = rgb2hsv_pkg::ValDen;
    b_next.val.quo = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
    end else if (en) begin
      a_vld <= s_axis_tvalid;
      b_vld <= a_vld;
    end
    if (en) begin
      a <= a_next;
      b <= b_next;
    end
  end

  // Divider: one quotient bit per stage, most significant first.
  for (genvar i = 0; i < DivStages; i++) begin : g_div
    localparam logic [2:0] Bit = 3'(DivStages - 1 - i);
    rgb2hsv_pkg::div_word_t src, step;
    logic                   src_vld;

    if (i == 0) begin : g_first
      assign src     = b;
      assign src_vld = b_vld;
    end else begin : g_rest
      assign src     = dv[i-1];
      assign src_vld = dv_vld[i-1];
    end

    always_comb begin
      step     = src;
      step.hue = rgb2hsv_pkg::div_step(src.hue, Bit);
      step.sat = rgb2hsv_pkg::div_step(src.sat, Bit);
      step.val = rgb2hsv_pkg::div_step(src.val, Bit);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[i] <= 1'b0;
      end else if (en) begin
        dv_vld[i] <= src_vld;
      end
      if (en) begin
        dv[i] <= step;
      end
    end
  end

  // Rounding stage.
  always_comb begin
    rgb2hsv_pkg::div_word_t last;
    last          = dv[DivStages-1];
    r_next.sector = last.sector;
    r_next.neg    = last.neg;
    r_next.black  = last.black;
    r_next.hue    = rgb2hsv_pkg::round_even(last.hue);
    r_next.sat    = last.black ? '0 : rgb2hsv_pkg::round_even(last.sat);
    r_next.val    = rgb2hsv_pkg::round_even(last.val);
  end

  // Hue assembly: sector base plus or minus the rounded offset, red wraps.
  always_comb begin
    logic [rgb2hsv_pkg::HueW-1:0] mag;
    mag = rgb2hsv_pkg::HueW'(r.hue);
    unique case (r.sector)
      rgb2hsv_pkg::SEC_GRAY:  hue_next = '0;
      rgb2hsv_pkg::SEC_RED:   hue_next = (r.neg && mag != '0) ? rgb2hsv_pkg::FullTurn - mag
                                                              : mag;
      rgb2hsv_pkg::SEC_GREEN: hue_next = r.neg ? rgb2hsv_pkg::GreenBase - mag
                                               : rgb2hsv_pkg::GreenBase + mag;
      rgb2hsv_pkg::SEC_BLUE:  hue_next = r.neg ? rgb2hsv_pkg::BlueBase - mag
                                               : rgb2hsv_pkg::BlueBase + mag;
      default:                hue_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_vld   <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      r_vld   <= dv_vld[DivStages-1];
      out_vld <= r_vld;
    end
    if (en) begin
      r       <= r_next;
      hue_deg <= hue_next;
      sat_pct <= r.sat;
      val_pct <= r.val;
    end
  end

`ifndef ASSERT_OFF
  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    dv_vld[DivStages-1] && dv[DivStages-1].hue.den != '0 && dv[DivStages-1].sat.den != '0
    |-> dv[DivStages-1].hue.rem < rgb2hsv_pkg::NumW'(dv[DivStages-1].hue.den) &&
        dv[DivStages-1].sat.rem < rgb2hsv_pkg::NumW'(dv[DivStages-1].sat.den) &&
        dv[DivStages-1].val.rem < rgb2hsv_pkg::NumW'(dv[DivStages-1].val.den))
    else $error("divider remainder not below divisor");

  a_gray_hue_zero: assert property (@(posedge clk) disable iff (rst)
    en && r_vld && r.sector == rgb2hsv_pkg::SEC_GRAY |=> hue_deg == '0 && sat_pct == '0)
    else $error("gray pixel gave nonzero hue or saturation");

  a_result_range: assert property (@(posedge clk) disable iff (rst)
    out_vld |-> hue_deg < rgb2hsv_pkg::FullTurn && sat_pct <= 7'd100 && val_pct <= 7'd100)
    else $error("result out of range");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable({a_vld, b_vld, dv_vld, r_vld}))
    else $error("valid bits moved during stall");

  a_word_advances: assert property (@(posedge clk) disable iff (rst)
    en && dv_vld[DivStages-1] |=> r_vld)
    else $error("word lost between divider and rounding");
`endif

endmodule

@@ test/testbench.sv @@
// Self-checking bench for rgb_to_hsv_converter: directed and random pixels under
// random source gaps and sink stalls, each result checked against an integer HSV predictor.
// Depends on rgb2hsv_pkg and rgb_to_hsv_converter.

module testbench;

  localparam int StallLimit = 2000;
  localparam int DrainCycles = 24;

  typedef struct packed {
    logic [rgb2hsv_pkg::HueW-1:0] hue;
    logic [rgb2hsv_pkg::PctW-1:0] sat;
    logic [rgb2hsv_pkg::PctW-1:0] val;
  } hsv_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  hsv_t pending_hsv[$];
  int   mismatches = 0;
  int   idle_cycles = 0;
  logic quiet = 1'b0;

  rgb_to_hsv_converter u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Round n/d to nearest, ties to even, symmetric in sign; d > 0.
  function automatic int div_nearest_even(input int n, input int d);
    int mag;
    int q;
    int r;
    mag = (n < 0) ? -n : n;
    q = mag / d;
    r = mag % d;
    if (2 * r > d || (2 * r == d && q[0]))
      q++;
    return (n < 0) ? -q : q;
  endfunction

  function automatic hsv_t hsv_of(input logic [23:0] word);
    int                   r;
    int                   g;
    int                   b;
    int                   hi;
    int                   lo;
    int                   span;
    int                   hue;
    int                   sat;
    rgb2hsv_pkg::sector_t sector;
    hsv_t                 res;
    r = int'(word[7:0]);
    g = int'(word[15:8]);
    b = int'(word[23:16]);
    hi = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
    lo = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
    span = hi - lo;
    if (span == 0)
      sector = rgb2hsv_pkg::SEC_GRAY;
    else if (hi == r)
      sector = rgb2hsv_pkg::SEC_RED;
    else if (hi == g)
      sector = rgb2hsv_pkg::SEC_GREEN;
    else
      sector = rgb2hsv_pkg::SEC_BLUE;
    case (sector)
      rgb2hsv_pkg::SEC_RED:   hue = div_nearest_even(60 * (g - b), span);
      rgb2hsv_pkg::SEC_GREEN: hue = div_nearest_even(60 * (b - r) + 120 * span, span);
      rgb2hsv_pkg::SEC_BLUE:  hue = div_nearest_even(60 * (r - g) + 240 * span, span);
      default:                hue = 0;
    endcase
    if (hue < 0)
      hue += 360;
    sat = (hi != 0) ? div_nearest_even(100 * span, hi) : 0;
    res.hue = rgb2hsv_pkg::HueW'(hue);
    res.sat = rgb2hsv_pkg::PctW'(sat);
    res.val = rgb2hsv_pkg::PctW'(div_nearest_even(100 * hi, 255));
    return res;
  endfunction

  // Mostly short pauses, a few long ones.
  function automatic int gap_len();
    if ($urandom_range(0, 99) < 85)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    quiet <= ($urandom_range(0, 3) == 0);
    repeat ($urandom_range(50, 400)) @(posedge clk);
  end

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    if (!quiet && $urandom_range(0, 99) < 30) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, g, r};
    do
      @(posedge clk);
    while (!s_axis_tready);
  endtask

  // Record the expected result of every accepted word.
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready)
      pending_hsv.push_back(hsv_of(s_axis_tdata));
  end

  always @(posedge clk) begin
    hsv_t got;
    hsv_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.hue = m_axis_tdata[8:0];
      got.sat = m_axis_tdata[15:9];
      got.val = m_axis_tdata[22:16];
      if (pending_hsv.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: hue %0d sat %0d val %0d", got.hue, got.sat, got.val);
        mismatches++;
      end else begin
        want = pending_hsv.pop_front();
        if (got.hue !== want.hue || got.sat !== want.sat || got.val !== want.val) begin
          if (mismatches < 10)
            $display("mismatch: expected hue %0d sat %0d val %0d, got hue %0d sat %0d val %0d",
                     want.hue, want.sat, want.val, got.hue, got.sat, got.val);
          mismatches++;
        end
      end
    end
  end

  initial begin
    while (rst)
      @(posedge clk);
    forever begin
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      if (!quiet) begin
        m_axis_tready <= 1'b0;
        repeat (gap_len()) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == StallLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic test_extremes();
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd1);
  endtask

  task automatic test_equal_maxima();
    send_pixel(8'd200, 8'd200, 8'd10);
    send_pixel(8'd10, 8'd200, 8'd200);
    send_pixel(8'd200, 8'd10, 8'd200);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd1, 8'd1, 8'd1);
  endtask

  task automatic test_rounding();
    send_pixel(8'd200, 8'd81, 8'd80);
    send_pixel(8'd200, 8'd83, 8'd80);
    send_pixel(8'd200, 8'd80, 8'd81);
    send_pixel(8'd255, 8'd0, 8'd1);
    send_pixel(8'd200, 8'd199, 8'd199);
    send_pixel(8'd200, 8'd197, 8'd197);
  endtask

  task automatic test_random_pixels(input int count);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] top;
    logic [7:0] low;
    int         kind;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(0, 99);
      r = 8'($urandom);
      g = 8'($urandom);
      b = 8'($urandom);
      top = 8'($urandom);
      low = 8'($urandom_range(0, int'(top)));
      if (kind < 10) begin
        g = r;
        b = r;
      end else if (kind < 25) begin
        case ($urandom_range(0, 2))
          0: begin
            r = top; g = top; b = low;
          end
          1: begin
            r = low; g = top; b = top;
          end
          default: begin
            r = top; g = low; b = top;
          end
        endcase
      end else if (kind < 40) begin
        g = r ^ 8'($urandom_range(0, 3));
        b = r ^ 8'($urandom_range(0, 3));
      end
      send_pixel(r, g, b);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_equal_maxima();
    test_rounding();
    test_random_pixels(1500);
    s_axis_tvalid <= 1'b0;
    while (pending_hsv.size() != 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
